@@ src/sdpid_pkg.sv @@
// shared widths, formats and register codes for the speed pid controller
package sdpid_pkg;

    // fixed point formats
    localparam int SPEED_FRAC_BITS = 8;
    localparam int GAIN_FRAC_BITS  = 16;
    localparam int FRAC_BITS       = SPEED_FRAC_BITS + GAIN_FRAC_BITS;

    // field and state widths
    localparam int SPEED_W     = 24;
    localparam int GAIN_W      = 32;
    localparam int DEAD_W      = 23;
    localparam int LIMIT_W     = 39;
    localparam int ERR_W       = SPEED_W + 1;
    localparam int DIFF_W      = ERR_W + 1;
    localparam int SUM_W       = 40;
    localparam int DRIVE_W     = 32;

    // integral product is split into two narrower partial products
    localparam int SUM_LO_W    = 20;
    localparam int SUM_HI_W    = SUM_W - SUM_LO_W;
    localparam int PROD_P_W    = GAIN_W + ERR_W;
    localparam int PROD_D_W    = GAIN_W + DIFF_W;
    localparam int PROD_LO_W   = GAIN_W + SUM_LO_W + 1;
    localparam int PROD_HI_W   = GAIN_W + SUM_HI_W;

    // accumulator holds the exact sum of all three terms
    localparam int ACC_W       = GAIN_W + SUM_W + 1;
    localparam int QUOT_W      = ACC_W - FRAC_BITS;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = LIMIT_W;

    localparam logic [DEAD_W-1:0] DEAD_BAND_RESET = DEAD_W'(128);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SETPOINT       = 3'd0,
        REG_KP             = 3'd1,
        REG_KI             = 3'd2,
        REG_KD             = 3'd3,
        REG_DEAD_BAND      = 3'd4,
        REG_INTEGRAL_LIMIT = 3'd5,
        REG_CLAMP_ENABLE   = 3'd6
    } cfg_reg_t;

endpackage

@@ src/sdpid_if.sv @@
// valid/ready channels for speed samples and drive values
interface sdpid_sample_if
    import sdpid_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] measured_speed;

    modport source (output valid, output measured_speed, input ready);
    modport sink   (input valid, input measured_speed, output ready);
endinterface

interface sdpid_drive_if
    import sdpid_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive_value;

    modport source (output valid, output drive_value, input ready);
    modport sink   (input valid, input drive_value, output ready);
endinterface

@@ src/speed_pid_deadband_clamp_unit.sv @@
// positional pid speed controller with dead band and integral clamp
//
//  channel   | direction | payload                      | handshake
//  ----------+-----------+------------------------------+-------------
//  sample    | in        | measured_speed  s24 (q.8)    | valid/ready
//  drive     | out       | drive_value     s32          | valid/ready
//  cfg       | in        | cfg_index 3b, cfg_data 39b   | cfg_write_en
//
// one request per cycle is accepted while the output is not stalled; each result
// passes the input, error/integral, multiply, accumulate and output registers.
// error_sum and previous_error update in the error stage, one item per cycle while it advances.
// rst_n clears all valid flags and the controller state; configuration registers reset, payload registers do not.
// each stage holds while the next is full, so a stalled result does not stop
// requests until the empty stages before it have filled.
module speed_pid_deadband_clamp_unit
    import sdpid_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    sdpid_sample_if.sink           sample,
    sdpid_drive_if.source          drive,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // rounding bias and its tie correction for negative sums
    localparam logic [ACC_W-1:0] ROUND_HALF =
        (FRAC_BITS > 0) ? (ACC_W'(1) << (FRAC_BITS - 1)) : '0;
    localparam logic ROUND_NEG_FIX = (FRAC_BITS > 0);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    // configuration registers
    logic signed [SPEED_W-1:0] setpoint_reg;
    logic signed [GAIN_W-1:0]  kp_reg;
    logic signed [GAIN_W-1:0]  ki_reg;
    logic signed [GAIN_W-1:0]  kd_reg;
    logic [DEAD_W-1:0]         dead_band_reg;
    logic [LIMIT_W-1:0]        integral_limit_reg;
    logic                      clamp_enable_reg;

    // controller state
    logic signed [SUM_W-1:0]   error_sum_reg;
    logic signed [ERR_W-1:0]   prev_error_reg;

    // pipeline registers
    logic                      s1_valid_reg;
    logic signed [SPEED_W-1:0] s1_meas_reg;
    logic                      s2_valid_reg;
    logic signed [ERR_W-1:0]   s2_e_reg;
    logic signed [SUM_W-1:0]   s2_sum_reg;
    logic signed [DIFF_W-1:0]  s2_de_reg;
    logic                      s3_valid_reg;
    logic signed [PROD_P_W-1:0]  s3_prod_p_reg;
    logic signed [PROD_D_W-1:0]  s3_prod_d_reg;
    logic signed [PROD_LO_W-1:0] s3_prod_lo_reg;
    logic signed [PROD_HI_W-1:0] s3_prod_hi_reg;
    logic                      s4_valid_reg;
    logic signed [ACC_W-1:0]   s4_acc_reg;
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_value_reg;

    // stage handshakes
    logic out_ready, s4_ready, s3_ready, s2_ready, s1_ready;
    logic in_take, s1_adv, s2_adv, s3_adv, s4_adv;

    // error stage signals
    logic signed [ERR_W-1:0]   err_raw;
    logic [ERR_W-1:0]          err_mag;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic signed [SUM_W-1:0]   limit_pos;
    logic signed [SUM_W-1:0]   limit_neg;
    logic signed [SUM_W-1:0]   sum_hi_clamp;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [DIFF_W-1:0]  de_next;

    // multiply stage signals
    logic signed [PROD_P_W-1:0]  prod_p_next;
    logic signed [PROD_D_W-1:0]  prod_d_next;
    logic signed [PROD_LO_W-1:0] prod_lo_next;
    logic signed [PROD_HI_W-1:0] prod_hi_next;

    // accumulate and round signals
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   rounded;
    logic signed [QUOT_W-1:0]  quot;
    logic signed [DRIVE_W-1:0] drive_next;

    // elastic ready chain, a stage moves when the next one is empty or moving
    assign out_ready    = !out_valid_reg || drive.ready;
    assign s4_ready     = !s4_valid_reg || out_ready;
    assign s3_ready     = !s3_valid_reg || s4_ready;
    assign s2_ready     = !s2_valid_reg || s3_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign sample.ready = s1_ready;
    assign in_take      = sample.valid && s1_ready;
    assign s1_adv       = s1_valid_reg && s2_ready;
    assign s2_adv       = s2_valid_reg && s3_ready;
    assign s3_adv       = s3_valid_reg && s4_ready;
    assign s4_adv       = s4_valid_reg && out_ready;

    assign drive.valid       = out_valid_reg;
    assign drive.drive_value = drive_value_reg;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg       <= '0;
            kp_reg             <= '0;
            ki_reg             <= '0;
            kd_reg             <= '0;
            dead_band_reg      <= DEAD_BAND_RESET;
            integral_limit_reg <= '0;
            clamp_enable_reg   <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SETPOINT:       setpoint_reg       <= cfg_data[SPEED_W-1:0];
                REG_KP:             kp_reg             <= cfg_data[GAIN_W-1:0];
                REG_KI:             ki_reg             <= cfg_data[GAIN_W-1:0];
                REG_KD:             kd_reg             <= cfg_data[GAIN_W-1:0];
                REG_DEAD_BAND:      dead_band_reg      <= cfg_data[DEAD_W-1:0];
                REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_CLAMP_ENABLE:   clamp_enable_reg   <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // error with dead band, saturating integral clamped when enabled, derivative
    always_comb
    begin
        err_raw  = ERR_W'(setpoint_reg) - ERR_W'(s1_meas_reg);
        err_mag  = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : ERR_W'(err_raw);
        err_next = (err_mag < ERR_W'(dead_band_reg)) ? '0 : err_raw;

        sum_wide = (SUM_W+1)'(error_sum_reg) + (SUM_W+1)'(err_next);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end

        limit_pos    = SUM_W'(integral_limit_reg);
        limit_neg    = -limit_pos;
        sum_hi_clamp = (sum_sat >= limit_pos) ? limit_pos : sum_sat;
        if (!clamp_enable_reg)
        begin
            sum_next = sum_sat;
        end
        else if (sum_hi_clamp <= limit_neg)
        begin
            sum_next = limit_neg;
        end
        else
        begin
            sum_next = sum_hi_clamp;
        end

        de_next = DIFF_W'(err_next) - DIFF_W'(prev_error_reg);
    end

    // three gains times their terms, integral split into high and low halves
    always_comb
    begin
        prod_p_next  = PROD_P_W'(kp_reg) * PROD_P_W'(s2_e_reg);
        prod_d_next  = PROD_D_W'(kd_reg) * PROD_D_W'(s2_de_reg);
        prod_lo_next = PROD_LO_W'(ki_reg)
                     * PROD_LO_W'($signed({1'b0, s2_sum_reg[SUM_LO_W-1:0]}));
        prod_hi_next = PROD_HI_W'(ki_reg)
                     * PROD_HI_W'($signed(s2_sum_reg[SUM_W-1:SUM_LO_W]));
    end

    // exact sum of all terms
    assign acc_next = ACC_W'(s3_prod_p_reg) + ACC_W'(s3_prod_d_reg)
                    + ACC_W'(s3_prod_lo_reg) + (ACC_W'(s3_prod_hi_reg) <<< SUM_LO_W);

    // round to nearest with ties away from zero, then saturate
    always_comb
    begin
        rounded = s4_acc_reg + $signed(ROUND_HALF)
                - ACC_W'(s4_acc_reg[ACC_W-1] && ROUND_NEG_FIX);
        quot    = QUOT_W'(rounded >>> FRAC_BITS);
        if (quot > QUOT_W'(DRIVE_MAX))
        begin
            drive_next = DRIVE_MAX;
        end
        else if (quot < QUOT_W'(DRIVE_MIN))
        begin
            drive_next = DRIVE_MIN;
        end
        else
        begin
            drive_next = quot[DRIVE_W-1:0];
        end
    end

    // valid flags and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s4_valid_reg;
            end
            if (s1_adv)
            begin
                error_sum_reg  <= sum_next;
                prev_error_reg <= err_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_meas_reg <= sample.measured_speed;
        end
        if (s1_adv)
        begin
            s2_e_reg   <= err_next;
            s2_sum_reg <= sum_next;
            s2_de_reg  <= de_next;
        end
        if (s2_adv)
        begin
            s3_prod_p_reg  <= prod_p_next;
            s3_prod_d_reg  <= prod_d_next;
            s3_prod_lo_reg <= prod_lo_next;
            s3_prod_hi_reg <= prod_hi_next;
        end
        if (s3_adv)
        begin
            s4_acc_reg <= acc_next;
        end
        if (s4_adv)
        begin
            drive_value_reg <= drive_next;
        end
    end

`ifndef SYNTHESIS
    // the stage after the error stage always sees the state it just wrote
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (s2_e_reg == prev_error_reg && s2_sum_reg == error_sum_reg))
        else $error("error stage and controller state disagree");

    // derivative is taken against the error left by the previous sample
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (s2_de_reg == (DIFF_W'(s2_e_reg) - DIFF_W'($past(prev_error_reg)))))
        else $error("derivative does not use the previous error");

    // an empty input stage always takes a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> sample.ready)
        else $error("input stage empty but request refused");

    // a finished sum reaches the output register when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        s4_adv |=> out_valid_reg)
        else $error("accumulated item lost before the output register");
`endif

endmodule
